@@ sv/lnds_pkg.sv @@
`default_nettype none

package lnds_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 16;
    localparam int RESULT_CAP = 64;

    localparam int VAL_W    = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int POS_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int LEN_BITS = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_TRACE
    } t_state;

    // search token travelling up the chain
    typedef struct packed {
        logic                vld;
        logic [VAL_W-1:0]    val;
        logic [LEN_BITS-1:0] len;
        logic [POS_BITS-1:0] pred;
        logic [POS_BITS-1:0] pos;
    } t_tok;

    // stored element, shifted up the chain during traceback
    typedef struct packed {
        logic [VAL_W-1:0]    val;
        logic [POS_BITS-1:0] pred;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/lnds_cell.sv @@
`default_nettype none

module lnds_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [lnds_pkg::POS_BITS-1:0]   i_idx,
    input  wire lnds_pkg::t_tok                  i_tok,
    output lnds_pkg::t_tok                       o_tok,
    input  wire logic                            i_shift,
    input  wire lnds_pkg::t_entry                i_below,
    output lnds_pkg::t_entry                     o_entry
);
    import lnds_pkg::*;

    t_tok                r_tok;
    t_tok                n_tok;
    logic [VAL_W-1:0]    r_val;
    logic [LEN_BITS-1:0] r_len;
    logic [POS_BITS-1:0] r_pred;
    logic [LEN_BITS:0]   w_cand;
    logic                w_fit;
    logic                w_wr;

    assign w_cand = {1'b0, r_len} + (LEN_BITS + 1)'(1);
    assign w_fit  = i_tok.vld && (i_idx < i_tok.pos) && (i_tok.val >= r_val)
                    && (w_cand >= {1'b0, i_tok.len});
    assign w_wr   = i_tok.vld && (i_idx == i_tok.pos);

    always_comb begin
        n_tok = i_tok;
        if (w_fit) begin
            // later candidate of equal length wins: nearest predecessor
            n_tok.len  = w_cand[LEN_BITS-1:0];
            n_tok.pred = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.val  <= n_tok.val;
        r_tok.len  <= n_tok.len;
        r_tok.pred <= n_tok.pred;
        r_tok.pos  <= n_tok.pos;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val  <= i_below.val;
            r_pred <= i_below.pred;
        end else if (w_wr) begin
            r_val  <= i_tok.val;
            r_len  <= i_tok.len;
            r_pred <= i_tok.pred;
        end
    end

    assign o_tok        = r_tok;
    assign o_entry.val  = r_val;
    assign o_entry.pred = r_pred;

endmodule

`default_nettype wire

@@ sv/longest_nondecreasing_subsequence.sv @@
`default_nettype none

// Longest non-decreasing subsequence over a sequence of up to MAX_ITEMS
// values; the beat with is_last set closes the sequence. Each stored beat
// launches a search token up a chain of MAX_ITEMS cells, one cell per cycle,
// so the input stalls after a stored beat until its token has left the top
// of the chain, and no new beat is taken before then. Beats beyond
// MAX_ITEMS are dropped in the cycle they arrive. After the last beat
// the chain shifts its contents out past the top end, one cell per cycle
// while the output is not stalled, and the matching elements are emitted
// from the end of the subsequence back to its start.
// The input is stalled during the search and the traceback.
module longest_nondecreasing_subsequence (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_value,
    input  wire logic        i_is_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_elem_value,
    output logic [5:0]       o_elem_position,
    output logic [6:0]       o_seq_length,
    output logic             o_last_of_run
);
    import lnds_pkg::*;

    t_state              r_state, n_state;
    logic [LEN_BITS-1:0] r_count, n_count;
    logic [LEN_BITS-1:0] r_best_len, n_best_len;
    logic [POS_BITS-1:0] r_best_end, n_best_end;
    logic                r_last, n_last;
    logic [POS_BITS-1:0] r_want, n_want;
    logic [LEN_BITS-1:0] r_remain, n_remain;
    logic [LEN_BITS-1:0] r_total, n_total;
    logic [POS_BITS-1:0] r_scan, n_scan;

    logic                r_out_vld;
    logic [VAL_W-1:0]    r_out_val;
    logic [POS_BITS-1:0] r_out_pos;
    logic [LEN_BITS-1:0] r_out_len;
    logic                r_out_last;

    logic                w_acc;
    logic                w_room;
    logic                w_free;
    logic                w_shift;
    logic                w_emit;
    logic                w_go;
    logic [LEN_BITS-1:0] w_go_len;
    logic [POS_BITS-1:0] w_go_end;
    t_tok                w_tok [MAX_ITEMS+1];
    t_entry              w_ent [MAX_ITEMS+1];
    t_tok                w_end;
    t_entry              w_top;

    assign o_stall = (r_state != ST_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign w_room  = (r_count < LEN_BITS'(MAX_ITEMS));
    assign w_free  = !r_out_vld || !i_stall;
    assign w_shift = (r_state == ST_TRACE) && w_free;
    assign w_emit  = w_shift && (r_scan == r_want);

    assign w_tok[0].vld  = w_acc && w_room;
    assign w_tok[0].val  = i_value[VAL_W-1:0];
    assign w_tok[0].len  = LEN_BITS'(1);
    assign w_tok[0].pred = r_count[POS_BITS-1:0];
    assign w_tok[0].pos  = r_count[POS_BITS-1:0];
    assign w_ent[0]      = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        lnds_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (POS_BITS'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_shift (w_shift),
            .i_below (w_ent[g]),
            .o_entry (w_ent[g+1])
        );
    end

    assign w_end = w_tok[MAX_ITEMS];
    assign w_top = w_ent[MAX_ITEMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_best_len <= '0;
            r_best_end <= '0;
            r_remain   <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_best_len <= n_best_len;
            r_best_end <= n_best_end;
            r_remain   <= n_remain;
        end
        r_last  <= n_last;
        r_want  <= n_want;
        r_total <= n_total;
        r_scan  <= n_scan;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_best_len = r_best_len;
        n_best_end = r_best_end;
        n_last     = r_last;
        n_want     = r_want;
        n_remain   = r_remain;
        n_total    = r_total;
        n_scan     = r_scan;
        w_go       = 1'b0;
        w_go_len   = r_best_len;
        w_go_end   = r_best_end;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (w_room) begin
                        n_state = ST_SEARCH;
                        n_last  = i_is_last;
                    end else if (i_is_last) begin
                        w_go = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                if (w_end.vld) begin
                    n_count = r_count + LEN_BITS'(1);
                    if (w_end.len > r_best_len) begin
                        n_best_len = w_end.len;
                        n_best_end = w_end.pos;
                        w_go_len   = w_end.len;
                        w_go_end   = w_end.pos;
                    end
                    if (r_last) begin
                        w_go = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TRACE: begin
                if (w_shift) begin
                    n_scan = r_scan - POS_BITS'(1);
                    if (w_emit) begin
                        n_want   = w_top.pred;
                        n_remain = r_remain - LEN_BITS'(1);
                        if (r_remain == LEN_BITS'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_go) begin
            n_state    = ST_TRACE;
            n_want     = w_go_end;
            n_total    = w_go_len;
            n_scan     = POS_BITS'(MAX_ITEMS - 1);
            n_remain   = (int'(w_go_len) > RESULT_CAP) ? LEN_BITS'(RESULT_CAP) : w_go_len;
            n_count    = '0;
            n_best_len = '0;
            n_best_end = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
        if (w_emit) begin
            r_out_val  <= w_top.val;
            r_out_pos  <= r_scan;
            r_out_len  <= r_total;
            r_out_last <= (r_remain == LEN_BITS'(1));
        end
    end

    assign o_valid         = r_out_vld;
    assign o_elem_value    = 16'(r_out_val);
    assign o_elem_position = 6'(r_out_pos);
    assign o_seq_length    = 7'(r_out_len);
    assign o_last_of_run   = r_out_last;

`ifndef SYNTH
    a_no_token_in_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SEARCH) |-> !w_end.vld)
        else $error("search token outside search");
    a_best_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_len <= r_count)
        else $error("best length exceeds element count");
    a_trace_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TRACE) |-> (r_remain != '0))
        else $error("traceback with nothing left to emit");
    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_vld)
        else $error("emitted element lost");
    a_last_ends_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_remain == LEN_BITS'(1))) |=> (r_state == ST_IDLE))
        else $error("traceback did not end after first element");
`endif

endmodule

`default_nettype wire

@@ test/longest_nondecreasing_subsequence_tb.sv @@
module longest_nondecreasing_subsequence_tb;

    import lnds_pkg::*;

    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BEATS   = 300;
    localparam int END_DRAIN      = 150;

    typedef enum {
        PAT_RANDOM,
        PAT_NARROW,
        PAT_RISING,
        PAT_FALLING,
        PAT_FLAT
    } t_pattern;

    typedef struct {
        logic [15:0] value;
        logic        last;
    } t_beat;

    typedef struct {
        logic [15:0] value;
        logic [5:0]  position;
        logic [6:0]  length;
        logic        last;
    } t_run_elem;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [15:0] i_value   = '0;
    logic        i_is_last = 1'b0;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_elem_value;
    logic [5:0]  o_elem_position;
    logic [6:0]  o_seq_length;
    logic        o_last_of_run;

    t_beat     pending_beats [$];
    t_run_elem expected_elems [$];

    // predictor state
    logic [15:0] seq_vals [MAX_ITEMS];
    int          run_len [MAX_ITEMS];
    int          pred_of [MAX_ITEMS];
    int          seq_count = 0;
    int          best_len  = 0;
    int          best_end  = 0;

    int   errors          = 0;
    int   idle_cycles     = 0;
    logic in_taken        = 1'b0;
    int   holds_requested = 0;
    int   holds_served    = 0;
    int   hold_left       = 0;
    int   calm_left       = 0;
    int   gap_left        = 0;
    int   calm_beats      = 0;
    t_beat drive_beat;

    longest_nondecreasing_subsequence i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_value         (i_value),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_elem_value    (o_elem_value),
        .o_elem_position (o_elem_position),
        .o_seq_length    (o_seq_length),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 70);
        return $urandom_range(71, 200);
    endfunction

    task automatic track_subsequence(input logic [15:0] value, input logic last);
        int pos;
        int len;
        int pred;
        int j;
        int k;
        int r;
        t_run_elem e;
        if (seq_count < MAX_ITEMS) begin
            pos  = seq_count;
            len  = 1;
            pred = pos;
            // nearest first, strictly longer replaces
            for (j = pos - 1; j >= 0; j--) begin
                if (run_len[j] + 1 > len && value >= seq_vals[j]) begin
                    len  = run_len[j] + 1;
                    pred = j;
                end
            end
            seq_vals[pos] = value;
            run_len[pos]  = len;
            pred_of[pos]  = pred;
            if (len > best_len) begin
                best_len = len;
                best_end = pos;
            end
            seq_count = pos + 1;
        end
        if (last) begin
            k = best_end;
            for (r = 0; r < best_len; r++) begin
                e.value    = seq_vals[k];
                e.position = k[5:0];
                e.length   = best_len[6:0];
                e.last     = (r == best_len - 1);
                expected_elems.push_back(e);
                k = pred_of[k];
            end
            seq_count = 0;
            best_len  = 0;
            best_end  = 0;
        end
    endtask

    task automatic check_elem();
        t_run_elem e;
        if (expected_elems.size() == 0) begin
            $error("unexpected result beat: value %0d position %0d",
                   o_elem_value, o_elem_position);
            errors++;
        end else begin
            e = expected_elems.pop_front();
            if (o_elem_value !== e.value) begin
                $error("elem_value: expected %0d, got %0d", e.value, o_elem_value);
                errors++;
            end
            if (o_elem_position !== e.position) begin
                $error("elem_position: expected %0d, got %0d", e.position, o_elem_position);
                errors++;
            end
            if (o_seq_length !== e.length) begin
                $error("seq_length: expected %0d, got %0d", e.length, o_seq_length);
                errors++;
            end
            if (o_last_of_run !== e.last) begin
                $error("last_of_run: expected %0d, got %0d", e.last, o_last_of_run);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) track_subsequence(i_value, i_is_last);
            if (o_valid && !i_stall) check_elem();
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                drive_beat = pending_beats.pop_front();
                i_valid   <= 1'b1;
                i_value   <= drive_beat.value;
                i_is_last <= drive_beat.last;
                if (calm_beats > 0) begin
                    calm_beats--;
                    gap_left = 0;
                end else if ($urandom_range(0, 9) == 0) begin
                    calm_beats = $urandom_range(5, 20);
                end else begin
                    gap_left = idle_span();
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (calm_left > 0) begin
            calm_left--;
            i_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                calm_left = $urandom_range(50, 300);
            end else begin
                hold_left = idle_span();
            end
            i_stall <= 1'b0;
        end
    end

    task automatic push_beat(input logic [15:0] value, input logic last);
        t_beat b;
        b.value = value;
        b.last  = last;
        pending_beats.push_back(b);
    endtask

    task automatic push_seq(input int len, input t_pattern pat);
        int cur;
        int i;
        cur = (pat == PAT_FALLING) ? $urandom_range(30000, 65535) : $urandom_range(0, 200);
        if (pat == PAT_FLAT) cur = $urandom_range(0, 65535);
        for (i = 0; i < len; i++) begin
            case (pat)
                PAT_RANDOM: cur = $urandom_range(0, 65535);
                PAT_NARROW: cur = $urandom_range(0, 7);
                PAT_RISING: begin
                    cur = cur + $urandom_range(0, 3);
                    if (cur > 65535) cur = 65535;
                end
                PAT_FALLING: begin
                    cur = cur - $urandom_range(1, 500);
                    if (cur < 0) cur = 0;
                end
                default: ;
            endcase
            push_beat(cur[15:0], i == len - 1);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || i_valid || expected_elems.size() != 0);
    endtask

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int sent;
        int len;
        int r;
        int i;
        t_pattern pat;

        // single element, both extremes
        push_beat(16'h0000, 1'b1);
        push_beat(16'hFFFF, 1'b1);
        // equal values chain
        for (i = 0; i < 4; i++) push_beat(16'h8000, i == 3);
        // strictly falling: nothing fits, end stays at position 0
        push_beat(16'hFFFF, 1'b0);
        push_beat(16'hC000, 1'b0);
        push_beat(16'h8000, 1'b0);
        push_beat(16'h0001, 1'b0);
        push_beat(16'h0000, 1'b1);
        // rising across the full range
        push_beat(16'h0000, 1'b0);
        push_beat(16'h5555, 1'b0);
        push_beat(16'hAAAA, 1'b0);
        push_beat(16'hFFFE, 1'b0);
        push_beat(16'hFFFF, 1'b1);
        // ties: nearest predecessor wins
        push_beat(16'd5, 1'b0);
        push_beat(16'd1, 1'b0);
        push_beat(16'd5, 1'b0);
        push_beat(16'd1, 1'b0);
        push_beat(16'd5, 1'b0);
        push_beat(16'd3, 1'b1);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();

        // long output hold while the next sequence is offered
        holds_requested++;
        push_seq(3, PAT_RANDOM);
        push_seq(4, PAT_NARROW);
        push_seq(2, PAT_RISING);
        sent = 9;
        wait_drained();

        // full store and overflow with ignored tail
        push_seq(MAX_ITEMS, PAT_NARROW);
        push_seq(MAX_ITEMS + 3, PAT_RISING);
        sent += 2 * MAX_ITEMS + 3;

        while (sent < RANDOM_BEATS) begin
            len = ($urandom_range(0, 14) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            r = $urandom_range(0, 9);
            if (r < 4) pat = PAT_RANDOM;
            else if (r < 7) pat = PAT_NARROW;
            else if (r == 7) pat = PAT_RISING;
            else if (r == 8) pat = PAT_FALLING;
            else pat = PAT_FLAT;
            push_seq(len, pat);
            sent += len;
        end

        wait_drained();
        repeat (END_DRAIN) @(posedge i_clk);
        if (expected_elems.size() != 0) begin
            $error("%0d result beats never arrived", expected_elems.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/lnds_pkg.sv
sv/lnds_cell.sv
sv/longest_nondecreasing_subsequence.sv
test/longest_nondecreasing_subsequence_tb.sv
